[hw/rtl/lrf_pkg.sv]
// Shared types and constants for the LCD rectangle fill command stream.
`timescale 1ns / 1ps
`default_nettype none
package lrf_pkg;

    // Request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Panel command bytes
    localparam logic [7:0] CMD_COL = 8'h2A;
    localparam logic [7:0] CMD_ROW = 8'h2B;
    localparam logic [7:0] CMD_MWR = 8'h2C;
    localparam logic [7:0] CMD_NOP = 8'h00;

    // Byte positions inside a window-set transaction group
    localparam logic [2:0] IDX_CMD      = 3'd0;
    localparam logic [2:0] IDX_START_HI = 3'd1;
    localparam logic [2:0] IDX_START_LO = 3'd2;
    localparam logic [2:0] IDX_END_HI   = 3'd3;
    localparam logic [2:0] IDX_END_LO   = 3'd4;

    localparam logic [15:0] CACHE_RESET = 16'hFFFF;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_COL  = 6'b000010,
        PH_ROW  = 6'b000100,
        PH_MWR  = 6'b001000,
        PH_PIX  = 6'b010000,
        PH_NOP  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [4:0]  red;
        logic [5:0]  green;
        logic [4:0]  blue;
    } rect_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } lcd_byte_t;

endpackage
`default_nettype wire

[hw/rtl/lrf_stream_if.sv]
// Valid/ready stream interface carrying one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface lrf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/lrf_seq.sv]
// Rectangle fill sequencer: window cache, phase state and next-byte selection.
`timescale 1ns / 1ps
`default_nettype none
module lrf_seq
    import lrf_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire rect_req_t req,
    output logic           res_valid,
    output lcd_byte_t      res
);

    phase_t                        phase_reg, phase_next;
    logic [2:0]                    byte_index_reg, byte_index_next;
    logic [PIXEL_COUNT_BITS-1:0]   pixels_left_reg, pixels_left_next;
    logic [15:0]                   col_start_reg, col_start_next;
    logic [15:0]                   col_end_reg, col_end_next;
    logic [15:0]                   row_start_reg, row_start_next;
    logic [15:0]                   row_end_reg, row_end_next;
    logic [15:0]                   win_y_reg, win_y_next;
    logic [15:0]                   win_h_reg, win_h_next;
    logic [15:0]                   color_reg, color_next;

    logic                          is_start;
    logic [31:0]                   product;
    logic                          count_sat;
    logic [PIXEL_COUNT_BITS-1:0]   pix_count;
    logic [PIXEL_COUNT_BITS-1:0]   pix_dec;
    logic [15:0]                   col_end_new;
    logic                          col_change;
    logic [15:0]                   row_y;
    logic [15:0]                   row_h;
    logic [15:0]                   row_end_new;
    logic                          row_change;
    logic [15:0]                   word_start;
    logic [15:0]                   word_end;
    logic [7:0]                    word_byte;

    assign is_start = (req.opcode == OP_START);

    assign product     = 32'(req.rect_width) * 32'(req.rect_height);
    assign count_sat   = (product >> PIXEL_COUNT_BITS) != 32'd0;
    assign pix_count   = count_sat ? {PIXEL_COUNT_BITS{1'b1}}
                                   : product[PIXEL_COUNT_BITS-1:0];
    assign pix_dec     = pixels_left_reg - 1'b1;

    assign col_end_new = req.x_start + req.rect_width + 16'hFFFF;
    assign col_change  = (req.x_start != col_start_reg) || (col_end_new != col_end_reg);

    // Row window comes from the request on a start, from the latch after columns
    assign row_y       = is_start ? req.y_start : win_y_reg;
    assign row_h       = is_start ? req.rect_height : win_h_reg;
    assign row_end_new = row_y + row_h + 16'hFFFF;
    assign row_change  = (row_y != row_start_reg) || (row_end_new != row_end_reg);

    assign word_start = (phase_reg == PH_COL) ? col_start_reg : row_start_reg;
    assign word_end   = (phase_reg == PH_COL) ? col_end_reg : row_end_reg;

    always_comb
    begin
        case (byte_index_reg)
            IDX_START_HI: word_byte = word_start[15:8];
            IDX_START_LO: word_byte = word_start[7:0];
            IDX_END_HI:   word_byte = word_end[15:8];
            default:      word_byte = word_end[7:0];
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        pixels_left_next = pixels_left_reg;
        col_start_next   = col_start_reg;
        col_end_next     = col_end_reg;
        row_start_next   = row_start_reg;
        row_end_next     = row_end_reg;
        win_y_next       = win_y_reg;
        win_h_next       = win_h_reg;
        color_next       = color_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (is_start)
        begin
            // Drop a request while a rectangle is in flight
            if (phase_reg == PH_IDLE)
            begin
                win_y_next       = req.y_start;
                win_h_next       = req.rect_height;
                color_next       = {req.red, req.green, req.blue};
                pixels_left_next = pix_count;
                byte_index_next  = IDX_CMD;
                if (col_change)
                begin
                    col_start_next = req.x_start;
                    col_end_next   = col_end_new;
                    phase_next     = PH_COL;
                end
                else if (row_change)
                begin
                    row_start_next = row_y;
                    row_end_next   = row_end_new;
                    phase_next     = PH_ROW;
                end
                else
                begin
                    phase_next = PH_MWR;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_COL, PH_ROW:
                begin
                    res_valid = 1'b1;
                    if (byte_index_reg == IDX_CMD)
                    begin
                        res.out_byte = (phase_reg == PH_COL) ? CMD_COL : CMD_ROW;
                        res.is_data  = 1'b0;
                    end
                    else
                    begin
                        res.out_byte = word_byte;
                        res.is_data  = 1'b1;
                    end
                    if (byte_index_reg >= IDX_END_LO)
                    begin
                        byte_index_next = IDX_CMD;
                        if (phase_reg == PH_COL && row_change)
                        begin
                            row_start_next = row_y;
                            row_end_next   = row_end_new;
                            phase_next     = PH_ROW;
                        end
                        else
                        begin
                            phase_next = PH_MWR;
                        end
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 3'd1;
                    end
                end
                PH_MWR:
                begin
                    res_valid       = 1'b1;
                    res.out_byte    = CMD_MWR;
                    byte_index_next = IDX_CMD;
                    phase_next      = (pixels_left_reg == '0) ? PH_NOP : PH_PIX;
                end
                PH_PIX:
                begin
                    res_valid   = 1'b1;
                    res.is_data = 1'b1;
                    if (byte_index_reg == IDX_CMD)
                    begin
                        res.out_byte    = color_reg[15:8];
                        byte_index_next = IDX_START_HI;
                    end
                    else
                    begin
                        res.out_byte     = color_reg[7:0];
                        byte_index_next  = IDX_CMD;
                        pixels_left_next = pix_dec;
                        if (pix_dec == '0)
                        begin
                            phase_next = PH_NOP;
                        end
                    end
                end
                PH_NOP:
                begin
                    res_valid       = 1'b1;
                    res.out_byte    = CMD_NOP;
                    res.last        = 1'b1;
                    phase_next      = PH_IDLE;
                    byte_index_next = IDX_CMD;
                end
                PH_IDLE:
                begin
                    res_valid = 1'b0;
                end
                default:
                begin
                    phase_next      = PH_IDLE;
                    byte_index_next = IDX_CMD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_index_reg  <= IDX_CMD;
            pixels_left_reg <= '0;
            col_start_reg   <= CACHE_RESET;
            col_end_reg     <= CACHE_RESET;
            row_start_reg   <= CACHE_RESET;
            row_end_reg     <= CACHE_RESET;
            win_y_reg       <= '0;
            win_h_reg       <= '0;
            color_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            pixels_left_reg <= pixels_left_next;
            col_start_reg   <= col_start_next;
            col_end_reg     <= col_end_next;
            row_start_reg   <= row_start_next;
            row_end_reg     <= row_end_next;
            win_y_reg       <= win_y_next;
            win_h_reg       <= win_h_next;
            color_reg       <= color_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lcd_rect_fill_command_stream_top.sv]
// Top level of the LCD rectangle fill command stream with its output register.
// A tick transaction's byte is registered on acceptance and appears on the output in the next cycle.
// Throughput: one request or tick transaction per cycle; the only stall is a full
// output register whose byte is not being taken in that cycle.
// Reset (rst_n, asynchronous): phase idle, window cache all ones, output empty.
// Start requests and ticks while idle produce no output transaction.
`timescale 1ns / 1ps
`default_nettype none
module lcd_rect_fill_command_stream_top
    import lrf_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lrf_stream_if.sink   rect,
    lrf_stream_if.source stream
);

    logic      accept;
    logic      res_valid;
    lcd_byte_t res;
    logic      out_valid_reg, out_valid_next;
    lcd_byte_t out_data_reg;

    // Take a new transaction whenever the output slot is empty or draining
    assign rect.ready = !out_valid_reg || stream.ready;
    assign accept     = rect.valid && rect.ready;

    lrf_seq #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .req       (rect.payload),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = res_valid;
        end
        else if (stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign stream.valid   = out_valid_reg;
    assign stream.payload = out_data_reg;

endmodule
`default_nettype wire

[tb/lcd_rect_fill_command_stream_top_test.sv]
// Self-checking testbench for the LCD rectangle fill command stream top level.
`timescale 1ns / 1ps
module lcd_rect_fill_command_stream_top_test;
    import lrf_pkg::*;

    localparam int RAND_ITEMS = 1800;

    typedef struct {
        rect_req_t req;
        bit        typed;
        bit        some;
        lcd_byte_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lrf_stream_if #(.payload_t(rect_req_t)) rect_if ();
    lrf_stream_if #(.payload_t(lcd_byte_t)) byte_if ();

    lcd_rect_fill_command_stream_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rect   (rect_if),
        .stream (byte_if)
    );

    always #4 clk = ~clk;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int fails = 0;

    lcd_byte_t exp_bytes[$];

    // Predicted sequencer state
    phase_t      fill_phase;
    logic [2:0]  fill_idx;
    logic [31:0] fill_pixels;
    logic [15:0] col_lo, col_hi, row_lo, row_hi;
    logic [15:0] win_y, win_h;
    logic [15:0] fill_color;

    // Last window sent by the random part, reused to hit the cache
    logic [15:0] last_x, last_y, last_w, last_h;

    function automatic void note_fail(string what);
        fails++;
        if (fails <= 10)
            $display("mismatch: %s", what);
    endfunction

    function automatic logic [7:0] window_byte(logic [15:0] lo, logic [15:0] hi,
                                               logic [2:0] idx);
        case (idx)
            IDX_START_HI: return lo[15:8];
            IDX_START_LO: return lo[7:0];
            IDX_END_HI:   return hi[15:8];
            default:      return hi[7:0];
        endcase
    endfunction

    // Skip the row-set group when the row pair matches the cache.
    function automatic void choose_rows();
        logic [15:0] y_end;
        y_end = win_y + win_h - 16'd1;
        fill_idx = IDX_CMD;
        if (win_y != row_lo || y_end != row_hi) begin
            row_lo = win_y;
            row_hi = y_end;
            fill_phase = PH_ROW;
        end
        else begin
            fill_phase = PH_MWR;
        end
    endfunction

    task automatic fill_step(input rect_req_t r, output bit produced, output lcd_byte_t res);
        logic [15:0] x_end;
        produced = 1'b0;
        res = '0;
        if (r.opcode == OP_START) begin
            // drop requests while busy
            if (fill_phase == PH_IDLE) begin
                win_y = r.y_start;
                win_h = r.rect_height;
                fill_color = {r.red, r.green, r.blue};
                fill_pixels = 32'(r.rect_width) * 32'(r.rect_height);
                x_end = r.x_start + r.rect_width - 16'd1;
                if (r.x_start != col_lo || x_end != col_hi) begin
                    col_lo = r.x_start;
                    col_hi = x_end;
                    fill_phase = PH_COL;
                    fill_idx = IDX_CMD;
                end
                else begin
                    choose_rows();
                end
            end
        end
        else begin
            case (fill_phase)
                PH_COL, PH_ROW:
                begin
                    produced = 1'b1;
                    if (fill_idx == IDX_CMD) begin
                        res.out_byte = (fill_phase == PH_COL) ? CMD_COL : CMD_ROW;
                    end
                    else begin
                        res.out_byte = (fill_phase == PH_COL)
                            ? window_byte(col_lo, col_hi, fill_idx)
                            : window_byte(row_lo, row_hi, fill_idx);
                        res.is_data = 1'b1;
                    end
                    if (fill_idx == IDX_END_LO) begin
                        if (fill_phase == PH_COL) begin
                            choose_rows();
                        end
                        else begin
                            fill_phase = PH_MWR;
                            fill_idx = IDX_CMD;
                        end
                    end
                    else begin
                        fill_idx = fill_idx + 3'd1;
                    end
                end
                PH_MWR:
                begin
                    produced = 1'b1;
                    res.out_byte = CMD_MWR;
                    fill_idx = IDX_CMD;
                    fill_phase = (fill_pixels == 32'd0) ? PH_NOP : PH_PIX;
                end
                PH_PIX:
                begin
                    produced = 1'b1;
                    res.is_data = 1'b1;
                    // high byte first, then low byte and advance the pixel count
                    if (!fill_idx[0]) begin
                        res.out_byte = fill_color[15:8];
                        fill_idx = 3'd1;
                    end
                    else begin
                        res.out_byte = fill_color[7:0];
                        fill_idx = 3'd0;
                        fill_pixels = fill_pixels - 32'd1;
                        if (fill_pixels == 32'd0)
                            fill_phase = PH_NOP;
                    end
                end
                PH_NOP:
                begin
                    produced = 1'b1;
                    res.out_byte = CMD_NOP;
                    res.last = 1'b1;
                    fill_phase = PH_IDLE;
                    fill_idx = 3'd0;
                end
                PH_IDLE:
                begin
                end
                default:
                begin
                    fill_phase = PH_IDLE;
                    fill_idx = 3'd0;
                end
            endcase
        end
    endtask

    function automatic rect_req_t rand_fields(logic op);
        rect_req_t r;
        r.opcode = op;
        r.x_start = 16'($urandom);
        r.y_start = 16'($urandom);
        r.rect_width = 16'($urandom);
        r.rect_height = 16'($urandom);
        r.red = 5'($urandom);
        r.green = 6'($urandom);
        r.blue = 5'($urandom);
        return r;
    endfunction

    // Mostly small rectangles; large sizes only where the other side is zero.
    function automatic rect_req_t rand_start();
        rect_req_t r;
        int roll;
        r = rand_fields(OP_START);
        roll = $urandom_range(99);
        if (roll < 30) begin
            r.x_start = last_x;
            r.y_start = last_y;
            r.rect_width = last_w;
            r.rect_height = last_h;
        end
        else if (roll < 42) begin
            r.x_start = last_x;
            r.rect_width = last_w;
            r.rect_height = (last_w > 16'd12) ? 16'd0 : 16'($urandom_range(4));
        end
        else if (roll < 54) begin
            r.y_start = last_y;
            r.rect_height = last_h;
            r.rect_width = (last_h > 16'd12) ? 16'd0 : 16'($urandom_range(4));
        end
        else begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                r.rect_width = 16'd0;
            end
            else if (roll < 20) begin
                r.rect_height = 16'd0;
            end
            else if (roll < 25) begin
                r.rect_width = 16'($urandom_range(12));
                r.rect_height = 16'($urandom_range(12));
            end
            else begin
                r.rect_width = 16'($urandom_range(4));
                r.rect_height = 16'($urandom_range(4));
            end
        end
        return r;
    endfunction

    function automatic dir_row_t start_row(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                                           logic [15:0] h, logic [4:0] r, logic [5:0] g,
                                           logic [4:0] b);
        dir_row_t row;
        row.req = '{OP_START, x, y, w, h, r, g, b};
        row.typed = 1'b1;
        row.some = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic dir_row_t tick_row(bit typed, bit some, logic [7:0] bval, logic dat,
                                          logic lst);
        dir_row_t row;
        row.req = rand_fields(OP_TICK);
        row.typed = typed;
        row.some = some;
        row.want = '{bval, dat, lst};
        return row;
    endfunction

    task automatic send_rect(input rect_req_t r, input bit typed, input bit typed_some,
                             input lcd_byte_t typed_byte);
        bit        got;
        lcd_byte_t pb;
        while ($urandom_range(99) < src_idle_pct) begin
            rect_if.valid <= 1'b0;
            @(negedge clk);
        end
        rect_if.valid <= 1'b1;
        rect_if.payload <= r;
        @(posedge clk);
        while (!rect_if.ready)
            @(posedge clk);
        fill_step(r, got, pb);
        if (typed) begin
            if (typed_some)
                exp_bytes.push_back(typed_byte);
        end
        else if (got) begin
            exp_bytes.push_back(pb);
        end
        @(negedge clk);
    endtask

    task automatic send_plain(input rect_req_t r);
        send_rect(r, 1'b0, 1'b0, '0);
    endtask

    always @(negedge clk)
        byte_if.ready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk) begin
        lcd_byte_t want;
        if (rst_n && byte_if.valid && byte_if.ready) begin
            if (exp_bytes.size() == 0) begin
                note_fail($sformatf("unexpected transaction %h/%b/%b",
                    byte_if.payload.out_byte, byte_if.payload.is_data,
                    byte_if.payload.last));
            end
            else begin
                want = exp_bytes.pop_front();
                if (byte_if.payload.out_byte !== want.out_byte
                        || byte_if.payload.is_data !== want.is_data
                        || byte_if.payload.last !== want.last)
                    note_fail($sformatf("byte/is_data/last expected %h/%b/%b got %h/%b/%b",
                        want.out_byte, want.is_data, want.last,
                        byte_if.payload.out_byte, byte_if.payload.is_data,
                        byte_if.payload.last));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        dir_row_t  dir_rows[$];
        rect_req_t r;
        int        counted;
        int        roll;

        rst_n = 1'b0;
        rect_if.valid = 1'b0;
        rect_if.payload = '0;
        byte_if.ready = 1'b0;
        col_lo = CACHE_RESET;
        col_hi = CACHE_RESET;
        row_lo = CACHE_RESET;
        row_hi = CACHE_RESET;
        fill_phase = PH_IDLE;
        fill_idx = 3'd0;
        fill_pixels = 32'd0;
        win_y = 16'd0;
        win_h = 16'd0;
        fill_color = 16'd0;
        last_x = 16'd0;
        last_y = 16'd0;
        last_w = 16'd1;
        last_h = 16'd1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tick while idle, then a one-pixel red fill against the reset cache
        dir_rows.push_back(tick_row(1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
        dir_rows.push_back(start_row(16'h0000, 16'h0000, 16'd1, 16'd1, 5'd31, 6'd0, 5'd0));
        dir_rows.push_back(tick_row(1'b1, 1'b1, CMD_COL, 1'b0, 1'b0));
        repeat (4) dir_rows.push_back(tick_row(1'b1, 1'b1, 8'h00, 1'b1, 1'b0));
        // request while busy: ignored
        dir_rows.push_back(start_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     5'd31, 6'd63, 5'd31));
        dir_rows.push_back(tick_row(1'b1, 1'b1, CMD_ROW, 1'b0, 1'b0));
        repeat (4) dir_rows.push_back(tick_row(1'b1, 1'b1, 8'h00, 1'b1, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b1, CMD_MWR, 1'b0, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 8'hF8, 1'b1, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 8'h00, 1'b1, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b1, CMD_NOP, 1'b0, 1'b1));
        // same window again: cache hit goes straight to memory write
        dir_rows.push_back(start_row(16'h0000, 16'h0000, 16'd1, 16'd1, 5'd0, 6'd63, 5'd31));
        dir_rows.push_back(tick_row(1'b1, 1'b1, CMD_MWR, 1'b0, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 8'h07, 1'b1, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 8'hFF, 1'b1, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b1, CMD_NOP, 1'b0, 1'b1));
        // zero width at the top corner: end coordinates wrap, no pixels
        dir_rows.push_back(start_row(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF,
                                     5'd0, 6'd0, 5'd0));
        repeat (3) dir_rows.push_back(tick_row(1'b0, 1'b0, 8'h00, 1'b0, 1'b0));

        foreach (dir_rows[i])
            send_rect(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].some, dir_rows[i].want);

        counted = 0;
        while (counted < RAND_ITEMS) begin
            case (counted * 4 / RAND_ITEMS)
                0: begin src_idle_pct = 0; snk_stall_pct = 0; end
                1: begin src_idle_pct = 62; snk_stall_pct = 0; end
                2: begin src_idle_pct = 0; snk_stall_pct = 62; end
                default: begin src_idle_pct = 37; snk_stall_pct = 37; end
            endcase
            roll = $urandom_range(99);
            if (fill_phase != PH_IDLE) begin
                if (roll < 6) begin
                    send_plain(rand_fields(OP_START));
                end
                else begin
                    send_plain(rand_fields(OP_TICK));
                    counted++;
                end
            end
            else if (roll < 8) begin
                send_plain(rand_fields(OP_TICK));
            end
            else begin
                r = rand_start();
                last_x = r.x_start;
                last_y = r.y_start;
                last_w = r.rect_width;
                last_h = r.rect_height;
                send_plain(r);
                counted++;
            end
        end
        // finish the rectangle in flight
        while (fill_phase != PH_IDLE)
            send_plain(rand_fields(OP_TICK));
        rect_if.valid <= 1'b0;

        while (exp_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (exp_bytes.size() != 0)
            note_fail($sformatf("%0d expected transactions never arrived", exp_bytes.size()));

        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
